// ----- sv/bda_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bda_pkg: shared types and constants for the binary to decimal ASCII block
// Radix, ASCII offset, reciprocal constant for divide by ten, sequencer states.
// ----------------------------------------------------------------------------
package bda_pkg;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned CHAR_W      = 6;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned WORD_DIGITS = 10;
  localparam int unsigned LEN_W       = $clog2(WORD_DIGITS + 1);
  localparam int unsigned QUOT_W      = 29;
  localparam int unsigned PROD_W      = 64;
  localparam int unsigned RECIP_SHIFT = 35;

  localparam logic [DIGIT_W-1:0] RADIX      = 4'd10;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;
  // ceil(2^35 / 10): exact quotient for every 32-bit dividend
  localparam logic [VALUE_W-1:0] RECIP      = 32'hCCCC_CCCD;

  // sequencer states, one-hot
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_PEEL = 3'b010,
    S_EMIT = 3'b100
  } bda_state_t;

endpackage : bda_pkg
`default_nettype wire

// ----- sv/bda_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bda_in_if / bda_out_if: valid/ready channels of the decimal ASCII block
// One transaction moves when valid and ready are both high at a clock edge.
// ----------------------------------------------------------------------------
interface bda_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface : bda_in_if

interface bda_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] digit_char;
  logic       last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink   (input valid, input digit_char, input last, output ready);
endinterface : bda_out_if
`default_nettype wire

// ----- sv/bda_div10.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bda_div10: shared divide-by-ten unit
// Registers a dividend and its product with the reciprocal of ten; the
// quotient and remainder of that dividend are read out the next cycle.
// ----------------------------------------------------------------------------
module bda_div10
  import bda_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [VALUE_W-1:0] operand,
  output logic      [QUOT_W-1:0]  quot,
  output logic      [DIGIT_W-1:0] rem
);

  logic [VALUE_W-1:0] dvd_r;
  logic [PROD_W-1:0]  prod_r;
  logic [PROD_W-1:0]  prod_nxt;
  logic [DIGIT_W-1:0] q_times_ten;

  // one 32x32 multiply into the product register
  assign prod_nxt = PROD_W'(operand) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      dvd_r  <= operand;
      prod_r <= prod_nxt;
    end
  end

  assign quot = prod_r[PROD_W-1:RECIP_SHIFT];

  // remainder is below ten, so the low four bits of v - 10q are enough
  assign q_times_ten = {quot[0], 3'b000} + {quot[2:0], 1'b0};
  assign rem         = dvd_r[DIGIT_W-1:0] - q_times_ten;

endmodule : bda_div10
`default_nettype wire

// ----- sv/binary_to_decimal_ascii.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii: unsigned 32-bit value to decimal ASCII digits
// Peels decimal digits with a shared divide-by-ten unit, then emits them
// most significant first, one ASCII character per output transaction.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one 32-bit unsigned value per transaction (valid/ready).
//   out_ch : one ASCII digit ('0'..'9') per transaction, last marks the
//            least significant digit. Leading zeros are suppressed; zero
//            gives a single '0'. With fewer than ten digit slots only the
//            low MAX_DIGITS digits are sent.
//   Flow   : accept loads the divider; the divide-by-ten loop (multiply
//            register feeds back its quotient) then peels one decimal digit
//            per pass, L = 1..10 digits, least significant first; then the
//            kept digits are emitted, min(L, MAX_DIGITS) of them, with
//            in_ch.ready low until the last digit is taken.
//   Stall  : while out_ch.ready is low the current digit is held.
//   Reset  : synchronous rst_n low returns the block to idle, ready for input,
//            with no output pending.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii
  import bda_pkg::*;
#(
  parameter int MAX_DIGITS = 10
)
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  bda_in_if.sink     in_ch,
  bda_out_if.source  out_ch
);

  localparam int SLOTS = (MAX_DIGITS < 1) ? 1 :
                         ((MAX_DIGITS > WORD_DIGITS) ? WORD_DIGITS : MAX_DIGITS);
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [LEN_W-1:0] SLOTS_L    = LEN_W'(SLOTS);
  localparam logic [LEN_W-1:0] LAST_LEN_L = LEN_W'(WORD_DIGITS - 1);
  localparam logic [IDX_W-1:0] TOP_IDX_L  = IDX_W'(SLOTS - 1);

  bda_state_t         state_r, state_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [IDX_W-1:0]   emit_r, emit_nxt;
  logic [DIGIT_W-1:0] dig_r [SLOTS];

  logic               in_acc;
  logic               out_acc;
  logic               div_en;
  logic [VALUE_W-1:0] div_operand;
  logic [QUOT_W-1:0]  quot;
  logic [DIGIT_W-1:0] rem;
  logic               peel_done;
  logic [LEN_W-1:0]   len_inc;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  // divider is loaded from the input on accept, from its own quotient after
  assign div_en      = in_acc || (state_r == S_PEEL);
  assign div_operand = (state_r == S_PEEL) ? VALUE_W'(quot) : in_ch.value;

  bda_div10 u_div10 (
    .clk     (clk),
    .en      (div_en),
    .operand (div_operand),
    .quot    (quot),
    .rem     (rem)
  );

  assign len_inc   = len_r + LEN_W'(1);
  assign peel_done = (quot == '0) || (len_r == LAST_LEN_L);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    emit_nxt  = emit_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_PEEL;
          len_nxt   = '0;
        end
      end
      S_PEEL: begin
        len_nxt = len_inc;
        if (peel_done) begin
          state_nxt = S_EMIT;
          // start at the most significant kept digit
          emit_nxt  = (len_inc > SLOTS_L) ? TOP_IDX_L : len_r[IDX_W-1:0];
        end
      end
      S_EMIT: begin
        if (out_acc) begin
          if (emit_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            emit_nxt = emit_r - IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
      emit_r  <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      emit_r  <= emit_nxt;
    end
  end

  // digit store, least significant at slot zero; digits past the slots drop
  always_ff @(posedge clk) begin
    if ((state_r == S_PEEL) && (len_r < SLOTS_L)) begin
      dig_r[len_r[IDX_W-1:0]] <= rem;
    end
  end

  // channel outputs
  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = (state_r == S_EMIT);
  assign out_ch.digit_char = ASCII_ZERO + CHAR_W'(dig_r[emit_r]);
  assign out_ch.last       = (emit_r == '0);

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("input ready while digits are pending");

  a_accept_peels: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_PEEL) && (len_r == '0))
    else $error("accepted value did not start the digit loop");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PEEL) |-> (rem < RADIX))
    else $error("divide-by-ten remainder out of range");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PEEL) |-> (len_r <= LAST_LEN_L))
    else $error("digit loop ran past ten digits");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_ch.last) |=> in_ch.ready && !out_ch.valid)
    else $error("block not idle after final digit");

endmodule : binary_to_decimal_ascii
`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for binary_to_decimal_ascii
// Feeds unsigned 32-bit values, predicts the decimal ASCII digit sequence of
// each one and checks every output transaction in order, with random idling
// on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb;
  import bda_pkg::*;

  localparam int DIGIT_SLOTS  = 10;
  localparam int KEEP_SLOTS   = (DIGIT_SLOTS < 1) ? 1 :
                                (DIGIT_SLOTS > WORD_DIGITS) ? WORD_DIGITS : DIGIT_SLOTS;
  localparam int RANDOM_ITEMS = 388;
  localparam int QUIET_LIMIT  = 2000;
  localparam int SHOW_MAX     = 10;

  typedef struct {
    logic [VALUE_W-1:0] value;
    bit                 drain;   // hold off until every digit has come back
  } value_item_t;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } digit_t;

  logic clk = 1'b0;
  logic rst_n;

  bda_in_if  in_ch ();
  bda_out_if out_ch ();

  binary_to_decimal_ascii #(
    .MAX_DIGITS(DIGIT_SLOTS)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  value_item_t value_q[$];   // values waiting to be sent
  digit_t      digit_q[$];   // digits still owed by the block

  int   total_items = 0;
  int   n_sent      = 0;
  int   n_values    = 0;
  int   n_digits    = 0;
  int   n_fail      = 0;
  int   quiet_cycles;
  int   phase       = 0;
  logic in_fire;

  // 2 ns high, 2 ns low
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Expected digit sequence of one value, most significant kept digit first
  function automatic void predict_digits(input logic [VALUE_W-1:0] value);
    logic [DIGIT_W-1:0] dig [WORD_DIGITS];
    logic [VALUE_W-1:0] rest;
    int                 len;
    int                 keep;
    digit_t             d;
    rest = value;
    len  = 0;
    if (value == '0) begin
      dig[0] = '0;
      len    = 1;
    end else begin
      while (rest != '0 && len < WORD_DIGITS) begin
        dig[len] = DIGIT_W'(rest % RADIX);
        rest     = rest / RADIX;
        len++;
      end
    end
    keep = (len > KEEP_SLOTS) ? KEEP_SLOTS : len;
    for (int k = keep - 1; k >= 0; k--) begin
      d.ch   = ASCII_ZERO + CHAR_W'(dig[k]);
      d.last = (k == 0);
      digit_q.push_back(d);
    end
  endfunction

  function automatic longint unsigned pow10(input int n);
    longint unsigned p;
    p = 1;
    for (int i = 0; i < n; i++) p = p * RADIX;
    return p;
  endfunction

  // Random value: raw, near a power of ten, zero-heavy or chosen digit count
  function automatic logic [VALUE_W-1:0] random_value();
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned acc;
    int              len;
    int              pick;
    pick = $urandom_range(99, 0);
    len  = $urandom_range(WORD_DIGITS, 1);
    if (pick < 20) begin
      return $urandom();
    end else if (pick < 30) begin
      // around a power of ten
      acc = pow10($urandom_range(9, 1));
      acc = acc + $urandom_range(2, 0) - 1;
      return VALUE_W'(acc);
    end else if (pick < 45) begin
      // mostly zero digits inside the number
      len = $urandom_range(9, 1);
      acc = $urandom_range(9, 1);
      for (int i = 1; i < len; i++) begin
        acc = acc * RADIX + (($urandom_range(3, 0) == 0) ? $urandom_range(9, 0) : 0);
      end
      return VALUE_W'(acc);
    end else begin
      lo = (len == 1) ? 0 : pow10(len - 1);
      hi = pow10(len) - 1;
      if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
      return $urandom_range(VALUE_W'(hi), VALUE_W'(lo));
    end
  endfunction

  // Stimulus, reset and end of run
  initial begin
    logic [VALUE_W-1:0] directed [$];
    value_item_t        it;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;

    directed = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd101,
                 32'd999, 32'd1000, 32'd12345, 32'd10203040, 32'd999999999,
                 32'd1000000000, 32'd1000000001, 32'd1234567890, 32'd2000000000,
                 32'd2147483647, 32'd2147483648, 32'd4000000000, 32'd4294967290,
                 32'd4294967294, 32'd4294967295};
    foreach (directed[i]) begin
      it.value = directed[i];
      it.drain = 1'b0;
      value_q.push_back(it);
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      it.value = random_value();
      it.drain = (i == 0) || ($urandom_range(39, 0) == 0);
      value_q.push_back(it);
    end
    total_items = value_q.size();

    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (value_q.size() != 0 || in_ch.valid) @(posedge clk);
    while (digit_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (digit_q.size() != 0) begin
      n_fail++;
      $display("%0d digits never arrived", digit_q.size());
    end
    $display("Converted %0d values (zero through 2^32-1, every digit count) into %0d digits",
             n_values, n_digits);
    $display("Ran free-flow, sender-idle, receiver-stall and mixed phases; %0d mismatches",
             n_fail);
    if (n_fail == 0) begin
      $display("[binary_to_decimal_ascii] OK");
    end else begin
      $display("[binary_to_decimal_ascii] ERROR");
    end
    $finish;
  end

  // Input driver: one value per transaction, random idle cycles per phase
  always @(negedge clk) begin
    logic               nxt_valid;
    logic [VALUE_W-1:0] nxt_value;
    int                 idle_pct;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!(in_ch.valid && !in_fire)) begin
      phase     = (total_items == 0) ? 0 : (n_sent * 4) / total_items;
      idle_pct  = (phase == 1) ? 59 : (phase == 3) ? 8 : 0;
      nxt_valid = 1'b0;
      nxt_value = in_ch.value;
      if (value_q.size() != 0 && !(value_q[0].drain && digit_q.size() != 0) &&
          $urandom_range(99, 0) >= idle_pct) begin
        nxt_valid = 1'b1;
        nxt_value = value_q.pop_front().value;
        n_sent++;
      end
      in_ch.valid <= nxt_valid;
      in_ch.value <= nxt_value;
    end
  end

  // Output receiver: random stalls per phase
  always @(negedge clk) begin
    int stall_pct;
    stall_pct = (phase == 2) ? 59 : (phase == 3) ? 8 : 0;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
    end
  end

  // Monitor: predict on input transactions, check output transactions
  always @(posedge clk) begin
    digit_t want;
    if (!rst_n) begin
      in_fire      <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      in_fire <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        predict_digits(in_ch.value);
        n_values++;
      end
      if (out_ch.valid && out_ch.ready) begin
        n_digits++;
        if (digit_q.size() == 0) begin
          n_fail++;
          if (n_fail <= SHOW_MAX)
            $display("%t: unexpected digit char=%0d last=%0b",
                     $realtime, out_ch.digit_char, out_ch.last);
        end else begin
          want = digit_q.pop_front();
          if (out_ch.digit_char !== want.ch || out_ch.last !== want.last) begin
            n_fail++;
            if (n_fail <= SHOW_MAX)
              $display("%t: digit mismatch: char exp %0d got %0d, last exp %0b got %0b",
                       $realtime, want.ch, out_ch.digit_char, want.last, out_ch.last);
          end
        end
      end
      // watchdog on cycles without any transaction
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("[binary_to_decimal_ascii] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule : tb

// ----- files.f -----
sv/bda_pkg.sv
sv/bda_if.sv
sv/bda_div10.sv
sv/binary_to_decimal_ascii.sv
bench/tb.sv
